### design/frm_pkg.sv
// Shared constants, types and codes of the frame rate meter.
package frm_pkg;

   localparam int SAMPLES_DEF = 16;

   localparam int TIME_W   = 32;
   localparam int GAP_W    = 16;
   localparam int AVG_W    = 24;
   localparam int TOTAL_W  = 48;
   localparam int COUNT_W  = 20;
   localparam int WTIME_W  = 40;
   localparam int FPS_W    = 24;
   localparam int WIN_W    = 16;
   localparam int CSR_W    = 24;
   localparam int PROD_W   = 30;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 40;
   localparam int DIV_Q_W   = 24;

   localparam logic [CSR_W-1:0] MAX_DELTA_RST = 24'd4267;
   localparam logic [WIN_W-1:0] WINDOW_MS_RST = 16'd1000;
   localparam logic [9:0]       MS_PER_S      = 10'd1000;
   localparam logic [FPS_W-1:0] SPEED_IDLE    = 24'd1000;
   localparam logic [FPS_W-1:0] FPS_ALL_ONES  = {FPS_W{1'b1}};
   localparam logic [GAP_W-1:0] GAP_MAX       = {GAP_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [WTIME_W-1:0] WTIME_MAX   = {WTIME_W{1'b1}};

   typedef enum logic [0:0] {
      CSR_MAX_DELTA = 1'b0,
      CSR_WINDOW_MS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_AVG,
      ST_ACCUM,
      ST_MUL,
      ST_FPS_GO,
      ST_FPS_WAIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_status_type;

endpackage

### design/frm_if.sv
// Handshake channels of the frame rate meter: tick requests and result beats.
interface frm_req_if;
   import frm_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface frm_rsp_if;
   import frm_pkg::*;

   logic               valid;
   logic               ready;
   logic [AVG_W-1:0]   avg_delta;
   logic [TOTAL_W-1:0] elapsed_time;
   logic [FPS_W-1:0]   fps;
   logic [FPS_W-1:0]   speed_factor;
   logic [FPS_W-1:0]   fps_min;
   logic [FPS_W-1:0]   fps_max;

   modport source (output valid, output avg_delta, output elapsed_time, output fps,
                   output speed_factor, output fps_min, output fps_max, input ready);
   modport sink   (input valid, input avg_delta, input elapsed_time, input fps,
                   input speed_factor, input fps_min, input fps_max, output ready);
endinterface

### design/frm_ram.sv
// Generic single-port-write, registered-read RAM.
module frm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### design/frm_div.sv
// Restoring divider, one quotient bit per cycle, saturating at the quotient width.
module frm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [frm_pkg::DIV_NUM_W-1:0]    num,
   input  logic [frm_pkg::DIV_DEN_W-1:0]    den,
   output frm_pkg::div_status_type          status
);
   import frm_pkg::*;

   localparam int HI_W  = DIV_NUM_W - DIV_Q_W;
   localparam int CNT_W = $clog2(DIV_Q_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sat_ff, sat_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   low_ff, low_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // The numerator's low bits shift out as quotient bits shift in.
   assign trial = {rem_ff, low_ff[DIV_Q_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         sat_in  = {{(DIV_DEN_W - HI_W){1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]} >= den;
         cnt_in  = CNT_W'(DIV_Q_W - 1);
         rem_in  = {{(DIV_DEN_W - HI_W){1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]};
         den_in  = den;
         low_in  = num[DIV_Q_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         low_in = {low_ff[DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
   end

   assign status.done = done_ff;
   assign status.quot = sat_ff ? {DIV_Q_W{1'b1}} : low_ff;
endmodule

### design/frame_rate_meter_core.sv
// Frame rate meter: ring of frame gaps, moving average, FPS window and min/max tracking.
// Each request beat is one frame tick with a millisecond timestamp; each tick yields exactly
// one response beat. Ticks are handled one at a time: the next tick is accepted only after
// the result of the previous one has been loaded. The states are, in order: READ for the
// ring memory read and ring update, AVG for the average gap (a multiply by the reciprocal
// of SAMPLES), ACCUM to accumulate the counters, MUL for the FPS numerator product, FPS_GO
// and FPS_WAIT for the FPS divider (load, 24 quotient steps, finish), FIN to load the
// response and IDLE to take the next tick. The gap ring lives in a SAMPLES-deep RAM;
// entries not yet written since reset read as zero through a wrap flag, so no clearing
// pass is needed after reset. A finished result waits in an output register, and the next
// tick is accepted while it waits; a tick that finishes while the previous result is still
// unread stalls until that result is taken.
module frame_rate_meter_core #(
   parameter int SAMPLES = frm_pkg::SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   frm_req_if.sink               req_chan,
   frm_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  frm_pkg::csr_index_type csr_index,
   input  logic [frm_pkg::CSR_W-1:0] csr_wdata
);
   import frm_pkg::*;

   localparam int POS_W = SAMPLES > 1 ? $clog2(SAMPLES) : 1;
   localparam int SUM_W = GAP_W + $clog2(SAMPLES);

   // The average is floor(sum * 256 / SAMPLES), taken as sum * M >> AVG_SH with M the
   // rounded-up reciprocal; this is exact for every sum the ring can hold.
   localparam int AVG_N  = SUM_W + 8;
   localparam int REC_SH = AVG_N + $clog2(SAMPLES);
   localparam int REC_W  = AVG_N + 1;
   localparam int AVG_SH = REC_SH - 8;
   localparam logic [63:0] REC_M64 =
      ((64'd1 << REC_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
   localparam logic [REC_W-1:0] AVG_RECIP = REC_M64[REC_W-1:0];

   state_type state_ff, state_in;

   logic [AVG_W-1:0]   max_delta_ff;
   logic [WIN_W-1:0]   window_ms_ff;

   logic [POS_W-1:0]   ring_pos_ff;
   logic               wrapped_ff;
   logic [SUM_W-1:0]   gap_sum_ff;
   logic [TIME_W-1:0]  prev_time_ff;
   logic               started_ff;
   logic [TOTAL_W-1:0] total_time_ff;
   logic [COUNT_W-1:0] frame_count_ff;
   logic [WTIME_W-1:0] window_time_ff;
   logic [TIME_W-1:0]  window_start_ff;
   logic [FPS_W-1:0]   low_fps_ff, low_fps_in;
   logic [FPS_W-1:0]   high_fps_ff, high_fps_in;

   logic [TIME_W-1:0]  now_ff;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic [AVG_W-1:0]   avg_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [FPS_W-1:0]   fps_ff;

   logic               rsp_valid_ff;
   logic [AVG_W-1:0]   rsp_avg_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [FPS_W-1:0]   rsp_fps_ff;
   logic [FPS_W-1:0]   rsp_speed_ff;
   logic [FPS_W-1:0]   rsp_min_ff;
   logic [FPS_W-1:0]   rsp_max_ff;

   logic               accept;
   logic               ring_we;
   logic               div_start;
   logic               rsp_load;
   logic               out_free;
   logic [GAP_W-1:0]   ring_rdata;
   logic [GAP_W-1:0]   old_gap;
   logic [TIME_W-1:0]  delta;
   logic [SUM_W+REC_W-1:0] avg_prod;
   logic [WTIME_W:0]   wtime_sum;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   div_status_type     div_status;
   logic               window_end;
   logic [FPS_W-1:0]   speed;

   frm_ram #(
      .WIDTH (GAP_W),
      .DEPTH (SAMPLES)
   ) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_pos_ff),
      .wdata (gap_ff),
      .raddr (ring_pos_ff),
      .rdata (ring_rdata)
   );

   frm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_chan.valid) state_in = ST_READ;
         ST_READ:     state_in = ST_AVG;
         ST_AVG:      state_in = ST_ACCUM;
         ST_ACCUM:    state_in = ST_MUL;
         ST_MUL:      state_in = ST_FPS_GO;
         ST_FPS_GO:   state_in = ST_FPS_WAIT;
         ST_FPS_WAIT: if (div_status.done) state_in = ST_FIN;
         ST_FIN:      if (out_free) state_in = ST_IDLE;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Control outputs of the sequencer.
   always_comb begin
      accept    = 1'b0;
      ring_we   = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   accept    = req_chan.valid;
         ST_READ:   ring_we   = 1'b1;
         ST_FPS_GO: div_start = 1'b1;
         ST_FIN:    rsp_load  = out_free;
         default: ;
      endcase
   end

   assign req_chan.ready = state_ff == ST_IDLE;

   // The first tick after reset has no previous time and counts as a zero gap.
   assign delta = req_chan.now_ms - prev_time_ff;
   always_comb begin
      if (!started_ff) begin
         gap_in = '0;
      end else if (delta > TIME_W'(GAP_MAX)) begin
         gap_in = GAP_MAX;
      end else begin
         gap_in = delta[GAP_W-1:0];
      end
   end

   assign old_gap   = wrapped_ff ? ring_rdata : '0;
   assign avg_prod  = (SUM_W + REC_W)'(gap_sum_ff) * (SUM_W + REC_W)'(AVG_RECIP);
   assign wtime_sum = {1'b0, window_time_ff} + (WTIME_W + 1)'(avg_ff);

   assign div_num = {2'd0, prod_ff, 16'd0};
   assign div_den = window_time_ff;

   assign window_end = (now_ff - window_start_ff) > TIME_W'(window_ms_ff);
   assign speed      = (gap_sum_ff == '0) ? SPEED_IDLE : FPS_W'(gap_sum_ff);

   // Min/max are taken before the window counters restart.
   always_comb begin
      low_fps_in  = low_fps_ff;
      high_fps_in = high_fps_ff;
      if (window_end && window_time_ff != '0) begin
         if (fps_ff < low_fps_ff) low_fps_in = fps_ff;
         if (fps_ff > high_fps_ff) high_fps_in = fps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_delta_ff    <= MAX_DELTA_RST;
         window_ms_ff    <= WINDOW_MS_RST;
         ring_pos_ff     <= '0;
         wrapped_ff      <= 1'b0;
         gap_sum_ff      <= '0;
         prev_time_ff    <= '0;
         started_ff      <= 1'b0;
         total_time_ff   <= '0;
         frame_count_ff  <= '0;
         window_time_ff  <= '0;
         window_start_ff <= '0;
         low_fps_ff      <= FPS_ALL_ONES;
         high_fps_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_DELTA: max_delta_ff <= csr_wdata;
               CSR_WINDOW_MS: window_ms_ff <= csr_wdata[WIN_W-1:0];
            endcase
         end
         if (accept) begin
            prev_time_ff <= req_chan.now_ms;
            started_ff   <= 1'b1;
         end
         if (ring_we) begin
            gap_sum_ff <= gap_sum_ff - SUM_W'(old_gap) + SUM_W'(gap_ff);
            if (ring_pos_ff == POS_W'(SAMPLES - 1)) begin
               ring_pos_ff <= '0;
               wrapped_ff  <= 1'b1;
            end else begin
               ring_pos_ff <= ring_pos_ff + 1'b1;
            end
         end
         if (state_ff == ST_ACCUM) begin
            total_time_ff <= total_time_ff + TOTAL_W'(avg_ff);
            if (frame_count_ff != COUNT_MAX) begin
               frame_count_ff <= frame_count_ff + 1'b1;
            end
            window_time_ff <= wtime_sum[WTIME_W] ? WTIME_MAX : wtime_sum[WTIME_W-1:0];
         end
         if (rsp_load) begin
            low_fps_ff  <= low_fps_in;
            high_fps_ff <= high_fps_in;
            if (window_end) begin
               frame_count_ff  <= '0;
               window_time_ff  <= '0;
               window_start_ff <= now_ff;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_chan.now_ms;
         gap_ff <= gap_in;
      end
      if (state_ff == ST_AVG) begin
         avg_ff <= avg_prod[AVG_SH +: AVG_W];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(frame_count_ff) * PROD_W'(MS_PER_S);
      end
      if (state_ff == ST_FPS_WAIT && div_status.done) begin
         fps_ff <= (window_time_ff == '0) ? '0 : div_status.quot;
      end
      if (rsp_load) begin
         rsp_avg_ff   <= (avg_ff > max_delta_ff) ? max_delta_ff : avg_ff;
         rsp_total_ff <= total_time_ff;
         rsp_fps_ff   <= fps_ff;
         rsp_speed_ff <= speed;
         rsp_min_ff   <= low_fps_in;
         rsp_max_ff   <= high_fps_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.avg_delta    = rsp_avg_ff;
   assign rsp_chan.elapsed_time = rsp_total_ff;
   assign rsp_chan.fps          = rsp_fps_ff;
   assign rsp_chan.speed_factor = rsp_speed_ff;
   assign rsp_chan.fps_min      = rsp_min_ff;
   assign rsp_chan.fps_max      = rsp_max_ff;
endmodule

### tb/sv/frame_rate_meter_core_tb.sv
// Self-checking testbench for frame_rate_meter_core: tick stimulus, rate prediction, result checks.
module frame_rate_meter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frm_pkg::*;

   localparam int SAMPLES = SAMPLES_DEF;

   typedef struct packed {
      logic [AVG_W-1:0]   avg_delta;
      logic [TOTAL_W-1:0] elapsed_time;
      logic [FPS_W-1:0]   fps;
      logic [FPS_W-1:0]   speed_factor;
      logic [FPS_W-1:0]   fps_min;
      logic [FPS_W-1:0]   fps_max;
   } rate_reading_type;

   // Tracks the meter's state tick by tick and holds the readings still owed by the block.
   class frame_rate_tally;
      logic [GAP_W-1:0]   gap_hist [SAMPLES];
      int unsigned        hist_pos;
      logic [19:0]        gap_sum;
      logic [TIME_W-1:0]  prev_stamp;
      bit                 seen_tick;
      logic [TOTAL_W-1:0] total_time;
      logic [COUNT_W-1:0] frame_count;
      logic [WTIME_W-1:0] window_time;
      logic [TIME_W-1:0]  window_start;
      logic [FPS_W-1:0]   low_fps;
      logic [FPS_W-1:0]   high_fps;
      logic [CSR_W-1:0]   max_delta;
      logic [WIN_W-1:0]   window_ms;
      rate_reading_type   due_readings [$];
      int unsigned        ticks_taken;
      int unsigned        beats_seen;
      int unsigned        errors;

      function new();
         foreach (gap_hist[i]) gap_hist[i] = '0;
         hist_pos     = 0;
         gap_sum      = '0;
         prev_stamp   = '0;
         seen_tick    = 0;
         total_time   = '0;
         frame_count  = '0;
         window_time  = '0;
         window_start = '0;
         low_fps      = FPS_ALL_ONES;
         high_fps     = '0;
         max_delta    = MAX_DELTA_RST;
         window_ms    = WINDOW_MS_RST;
         ticks_taken  = 0;
         beats_seen   = 0;
         errors       = 0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
      endtask

      function void note_tick(logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0]  step;
         logic [TIME_W-1:0]  since_start;
         logic [GAP_W-1:0]   gap;
         logic [63:0]        avg_wide;
         logic [63:0]        rate_wide;
         logic [WTIME_W:0]   wsum;
         logic [AVG_W-1:0]   avg;
         logic [FPS_W-1:0]   fps;
         rate_reading_type   r;

         ticks_taken++;
         gap = '0;
         if (seen_tick) begin
            step = stamp - prev_stamp;
            gap = (step > TIME_W'(GAP_MAX)) ? GAP_MAX : step[GAP_W-1:0];
         end
         seen_tick  = 1;
         prev_stamp = stamp;

         gap_sum = gap_sum - 20'(gap_hist[hist_pos]) + 20'(gap);
         gap_hist[hist_pos] = gap;
         hist_pos = (hist_pos + 1) % SAMPLES;

         avg_wide = ({44'd0, gap_sum} << 8) / 64'(SAMPLES);
         avg = (avg_wide > 64'(FPS_ALL_ONES)) ? FPS_ALL_ONES : avg_wide[AVG_W-1:0];
         total_time = total_time + TOTAL_W'(avg);

         if (frame_count != COUNT_MAX) frame_count++;
         wsum = {1'b0, window_time} + (WTIME_W+1)'(avg);
         window_time = wsum[WTIME_W] ? WTIME_MAX : wsum[WTIME_W-1:0];

         // The rate is taken from this tick's counters, before a window restart.
         if (window_time == '0) begin
            fps = '0;
         end else begin
            rate_wide = (64'(frame_count) * 64'd65536000) / 64'(window_time);
            fps = (rate_wide > 64'(FPS_ALL_ONES)) ? FPS_ALL_ONES : rate_wide[FPS_W-1:0];
         end

         r.speed_factor = (gap_sum == '0) ? SPEED_IDLE : FPS_W'(gap_sum);

         since_start = stamp - window_start;
         if (since_start > TIME_W'(window_ms)) begin
            // A window with no measured time leaves the extremes alone.
            if (window_time != '0) begin
               if (fps < low_fps) low_fps = fps;
               if (fps > high_fps) high_fps = fps;
            end
            frame_count  = '0;
            window_time  = '0;
            window_start = stamp;
         end

         r.avg_delta    = (avg > max_delta) ? max_delta : avg;
         r.elapsed_time = total_time;
         r.fps          = fps;
         r.fps_min      = low_fps;
         r.fps_max      = high_fps;
         due_readings.push_back(r);
      endfunction

      task check_result(rate_reading_type got);
         rate_reading_type want;
         beats_seen++;
         if (due_readings.size() == 0) begin
            report($sformatf("beat %0d arrived with no tick outstanding", beats_seen));
            return;
         end
         want = due_readings.pop_front();
         if (got.avg_delta !== want.avg_delta)
            report($sformatf("beat %0d avg_delta got %0d want %0d",
                             beats_seen, got.avg_delta, want.avg_delta));
         if (got.elapsed_time !== want.elapsed_time)
            report($sformatf("beat %0d elapsed_time got %0d want %0d",
                             beats_seen, got.elapsed_time, want.elapsed_time));
         if (got.fps !== want.fps)
            report($sformatf("beat %0d fps got %0d want %0d",
                             beats_seen, got.fps, want.fps));
         if (got.speed_factor !== want.speed_factor)
            report($sformatf("beat %0d speed_factor got %0d want %0d",
                             beats_seen, got.speed_factor, want.speed_factor));
         if (got.fps_min !== want.fps_min)
            report($sformatf("beat %0d fps_min got %0d want %0d",
                             beats_seen, got.fps_min, want.fps_min));
         if (got.fps_max !== want.fps_max)
            report($sformatf("beat %0d fps_max got %0d want %0d",
                             beats_seen, got.fps_max, want.fps_max));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [CSR_W-1:0]   csr_wdata;
   bit                 quiet = 1'b0;
   bit                 pressure_hold = 1'b0;
   frame_rate_tally    tally;

   frm_req_if req_bus ();
   frm_rsp_if rsp_bus ();

   frame_rate_meter_core #(.SAMPLES(SAMPLES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic send_tick(input logic [TIME_W-1:0] stamp);
      int unsigned idle;
      idle = quiet ? 0 : $urandom_range(0, 3);
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.now_ms <= stamp;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      tally.note_tick(stamp);
   endtask

   // Mostly steady frame pacing, with stalls, long pauses, clock jumps and wild stamps mixed in.
   function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] last);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return last + $urandom_range(1, 40);
      if (pick < 75) return last;
      if (pick < 85) return last + $urandom_range(41, 3000);
      if (pick < 91) return last + $urandom_range(65536, 32'h00FF_FFFF);
      if (pick < 96) return last - $urandom_range(1, 5000);
      return $urandom();
   endfunction

   task automatic run_random(input int unsigned count, inout logic [TIME_W-1:0] stamp);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0) quiet <= ($urandom_range(0, 3) == 0);
         stamp = next_stamp(stamp);
         send_tick(stamp);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tally.due_readings.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_W-1:0] delta, input logic [WIN_W-1:0] win);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_DELTA;
      csr_wdata <= delta;
      @(posedge clock);
      tally.max_delta = delta;
      csr_index <= CSR_WINDOW_MS;
      csr_wdata <= CSR_W'(win);
      @(posedge clock);
      tally.window_ms = win;
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] opening [$];
      logic [CSR_W-1:0]  delta_set [5];
      logic [WIN_W-1:0]  window_set [5];

      tally = new();
      csr_we         <= 1'b0;
      csr_index      <= CSR_MAX_DELTA;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.now_ms <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First tick far past the window start ends an empty window; a run of equal stamps
      // then one millisecond drives the rate into saturation; later come a window end with
      // a measured rate, a saturated gap and wraps of the millisecond clock.
      opening = '{32'd5000, 32'd5000, 32'd5000, 32'd5000, 32'd5000, 32'd5001,
                  32'd5017, 32'd5033, 32'd5050, 32'd5066, 32'd7000, 32'd77000,
                  32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0010,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_000F};
      foreach (opening[i]) send_tick(opening[i]);
      stamp = opening[opening.size()-1];
      run_random(200, stamp);

      delta_set  = '{24'd0, 24'hFFFFFF, 24'($urandom()), 24'($urandom_range(0, 8000)),
                     MAX_DELTA_RST};
      window_set = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)),
                     16'($urandom_range(1, 200)), WINDOW_MS_RST};
      for (int p = 0; p < 5; p++) begin
         drain();
         write_config(delta_set[p], window_set[p]);
         run_random(200, stamp);
      end

      drain();
      repeat (80) @(posedge clock);
      if (tally.due_readings.size() != 0)
         tally.report($sformatf("%0d readings never arrived", tally.due_readings.size()));
      if (tally.errors == 0) begin
         $display("** frame_rate_meter_core: PASSED **");
      end else begin
         $display("** frame_rate_meter_core: FAILED **");
      end
      $finish;
   end

   initial begin
      rate_reading_type got;
      int unsigned      hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.avg_delta    = rsp_bus.avg_delta;
            got.elapsed_time = rsp_bus.elapsed_time;
            got.fps          = rsp_bus.fps;
            got.speed_factor = rsp_bus.speed_factor;
            got.fps_min      = rsp_bus.fps_min;
            got.fps_max      = rsp_bus.fps_max;
            tally.check_result(got);
            hold = quiet ? 0 : $urandom_range(0, 3);
         end
         if (pressure_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Hold the result side off long enough that the block backs up into its tick input.
   initial begin
      @(negedge reset);
      while (tally.ticks_taken < 60) @(posedge clock);
      pressure_hold <= 1'b1;
      repeat (500) @(posedge clock);
      pressure_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("** frame_rate_meter_core: FAILED **");
      $finish;
   end

endmodule
